@@ sv/quicksort_engine_top_macros.svh @@
// ----------------------------------------------------------------------------
// Quicksort engine assertion macros
// Concurrent assertion wrappers used by the RTL; empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef QUICKSORT_ENGINE_TOP_MACROS_SVH
`define QUICKSORT_ENGINE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every rising edge outside reset.
`define QSE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define QSE_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QSE_ASSERT(label, clk, rst, prop, msg)
`define QSE_ASSERT_NR(label, clk, prop, msg)
`endif

`endif

@@ sv/qse_pkg.sv @@
// ----------------------------------------------------------------------------
// Quicksort engine package
// Sizes, transaction payload types and the request structs between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package qse_pkg;

  localparam int MAX_ITEMS = 32;
  localparam int VALUE_W   = 32;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int STK_W     = 2 * IDX_W;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last_item;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      last_out;
    logic                      overflow;
  } out_item_t;

  // Element store port request.
  typedef struct packed {
    logic                      we;
    logic [IDX_W-1:0]          waddr;
    logic signed [VALUE_W-1:0] wdata;
    logic [IDX_W-1:0]          raddr;
  } store_req_t;

  // Range stack port request; an entry is {lo, hi}.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [STK_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } stack_req_t;

  typedef struct packed {
    logic      valid;
    out_item_t data;
  } emit_t;

endpackage

`default_nettype wire

@@ sv/qse_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module qse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/qse_sequencer.sv @@
// ----------------------------------------------------------------------------
// Quicksort sequencer
// Loads the set, runs Hoare partitioning with one shared comparator over the
// element store, keeps pending ranges on the range stack and emits results.
// ----------------------------------------------------------------------------
`default_nettype none
`include "quicksort_engine_top_macros.svh"

module qse_sequencer (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              item_valid,
  input  wire qse_pkg::in_item_t                 item,
  output logic                                   item_ready,
  input  wire logic signed [qse_pkg::VALUE_W-1:0] store_rdata,
  input  wire logic [qse_pkg::STK_W-1:0]         stack_rdata,
  input  wire logic                              out_free,
  output qse_pkg::store_req_t                    store_req,
  output qse_pkg::stack_req_t                    stack_req,
  output qse_pkg::emit_t                         emit
);

  import qse_pkg::*;

  typedef enum logic [17:0] {
    ST_LOAD    = 18'h00001,
    ST_INIT    = 18'h00002,
    ST_POP     = 18'h00004,
    ST_POP_WT  = 18'h00008,
    ST_PIVOT   = 18'h00010,
    ST_SI_RD   = 18'h00020,
    ST_SI_CMP  = 18'h00040,
    ST_SJ_RD   = 18'h00080,
    ST_SJ_CMP  = 18'h00100,
    ST_DECIDE  = 18'h00200,
    ST_SWAP_I  = 18'h00400,
    ST_SWAP_J  = 18'h00800,
    ST_FIN_LO  = 18'h01000,
    ST_FIN_J   = 18'h02000,
    ST_PUSH_A  = 18'h04000,
    ST_PUSH_B  = 18'h08000,
    ST_EM_RD   = 18'h10000,
    ST_EM_WAIT = 18'h20000
  } state_t;

  state_t state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic             ovf, ovf_next;
  logic [CNT_W-1:0] sp, sp_next;
  logic [CNT_W-1:0] lo, lo_next;
  logic [CNT_W-1:0] hi, hi_next;
  logic [CNT_W-1:0] i, i_next;
  logic [CNT_W-1:0] j, j_next;
  logic [CNT_W-1:0] k, k_next;
  logic signed [VALUE_W-1:0] pivot, pivot_next;
  logic signed [VALUE_W-1:0] vi, vi_next;
  logic signed [VALUE_W-1:0] vj, vj_next;

  // Child ranges of the finished partition; the pivot index sits in j.
  logic             left_ok, right_ok, left_big;
  logic [STK_W-1:0] left_ent, right_ent;
  logic [CNT_W-1:0] pop_lo;

  always_comb begin
    left_ok   = (lo + CNT_W'(1)) < j;
    right_ok  = (j + CNT_W'(1)) < hi;
    left_big  = (j - lo) > (hi - j);
    left_ent  = {lo[IDX_W-1:0], j[IDX_W-1:0] - IDX_W'(1)};
    right_ent = {j[IDX_W-1:0] + IDX_W'(1), hi[IDX_W-1:0]};
    pop_lo    = CNT_W'(stack_rdata[STK_W-1:IDX_W]);
  end

  always_comb begin
    state_next = state;
    count_next = count;
    ovf_next   = ovf;
    sp_next    = sp;
    lo_next    = lo;
    hi_next    = hi;
    i_next     = i;
    j_next     = j;
    k_next     = k;
    pivot_next = pivot;
    vi_next    = vi;
    vj_next    = vj;
    store_req  = '0;
    stack_req  = '0;
    emit       = '0;
    item_ready = (state == ST_LOAD);

    unique case (state)
      ST_LOAD: begin
        if (item_valid) begin
          if (count < CNT_W'(MAX_ITEMS)) begin
            store_req.we    = 1'b1;
            store_req.waddr = count[IDX_W-1:0];
            store_req.wdata = item.value;
            count_next      = count + CNT_W'(1);
          end else begin
            ovf_next = 1'b1;
          end
          if (item.last_item) begin
            state_next = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        sp_next = '0;
        if (count > CNT_W'(1)) begin
          stack_req.we    = 1'b1;
          stack_req.waddr = '0;
          stack_req.wdata = {IDX_W'(0), count[IDX_W-1:0] - IDX_W'(1)};
          sp_next         = CNT_W'(1);
        end
        state_next = ST_POP;
      end
      ST_POP: begin
        if (sp == '0) begin
          k_next     = '0;
          state_next = ST_EM_RD;
        end else begin
          stack_req.raddr = sp[IDX_W-1:0] - IDX_W'(1);
          sp_next         = sp - CNT_W'(1);
          state_next      = ST_POP_WT;
        end
      end
      ST_POP_WT: begin
        lo_next         = pop_lo;
        hi_next         = CNT_W'(stack_rdata[IDX_W-1:0]);
        i_next          = pop_lo + CNT_W'(1);
        j_next          = CNT_W'(stack_rdata[IDX_W-1:0]);
        store_req.raddr = stack_rdata[STK_W-1:IDX_W];
        state_next      = ST_PIVOT;
      end
      ST_PIVOT: begin
        pivot_next = store_rdata;
        state_next = ST_SI_RD;
      end
      ST_SI_RD: begin
        if (i <= hi) begin
          store_req.raddr = i[IDX_W-1:0];
          state_next      = ST_SI_CMP;
        end else begin
          state_next = ST_SJ_RD;
        end
      end
      ST_SI_CMP: begin
        if (store_rdata <= pivot) begin
          i_next     = i + CNT_W'(1);
          state_next = ST_SI_RD;
        end else begin
          vi_next    = store_rdata;
          state_next = ST_SJ_RD;
        end
      end
      ST_SJ_RD: begin
        if (j >= lo + CNT_W'(1)) begin
          store_req.raddr = j[IDX_W-1:0];
          state_next      = ST_SJ_CMP;
        end else begin
          state_next = ST_DECIDE;
        end
      end
      ST_SJ_CMP: begin
        if (store_rdata >= pivot) begin
          j_next     = j - CNT_W'(1);
          state_next = ST_SJ_RD;
        end else begin
          vj_next    = store_rdata;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_next = (i < j) ? ST_SWAP_I : ST_FIN_LO;
      end
      ST_SWAP_I: begin
        store_req.we    = 1'b1;
        store_req.waddr = i[IDX_W-1:0];
        store_req.wdata = vj;
        state_next      = ST_SWAP_J;
      end
      ST_SWAP_J: begin
        store_req.we    = 1'b1;
        store_req.waddr = j[IDX_W-1:0];
        store_req.wdata = vi;
        state_next      = ST_SI_RD;
      end
      ST_FIN_LO: begin
        // The pivot slot is never written during the scans, so when j fell
        // back to lo the element there is still the pivot itself.
        store_req.we    = 1'b1;
        store_req.waddr = lo[IDX_W-1:0];
        store_req.wdata = (j == lo) ? pivot : vj;
        state_next      = ST_FIN_J;
      end
      ST_FIN_J: begin
        store_req.we    = 1'b1;
        store_req.waddr = j[IDX_W-1:0];
        store_req.wdata = pivot;
        state_next      = ST_PUSH_A;
      end
      ST_PUSH_A: begin
        // The larger part goes on first so that the smaller one runs next.
        if ((left_big ? left_ok : right_ok) && sp < CNT_W'(MAX_ITEMS)) begin
          stack_req.we    = 1'b1;
          stack_req.waddr = sp[IDX_W-1:0];
          stack_req.wdata = left_big ? left_ent : right_ent;
          sp_next         = sp + CNT_W'(1);
        end
        state_next = ST_PUSH_B;
      end
      ST_PUSH_B: begin
        if ((left_big ? right_ok : left_ok) && sp < CNT_W'(MAX_ITEMS)) begin
          stack_req.we    = 1'b1;
          stack_req.waddr = sp[IDX_W-1:0];
          stack_req.wdata = left_big ? right_ent : left_ent;
          sp_next         = sp + CNT_W'(1);
        end
        state_next = ST_POP;
      end
      ST_EM_RD: begin
        store_req.raddr = k[IDX_W-1:0];
        state_next      = ST_EM_WAIT;
      end
      ST_EM_WAIT: begin
        store_req.raddr = k[IDX_W-1:0];
        if (out_free) begin
          emit.valid             = 1'b1;
          emit.data.sorted_value = store_rdata;
          emit.data.last_out     = (k == count - CNT_W'(1));
          emit.data.overflow     = ovf;
          if (k == count - CNT_W'(1)) begin
            count_next = '0;
            ovf_next   = 1'b0;
            state_next = ST_LOAD;
          end else begin
            k_next     = k + CNT_W'(1);
            state_next = ST_EM_RD;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
      ovf   <= 1'b0;
      sp    <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      ovf   <= ovf_next;
      sp    <= sp_next;
    end
  end

  always_ff @(posedge clk) begin
    lo    <= lo_next;
    hi    <= hi_next;
    i     <= i_next;
    j     <= j_next;
    k     <= k_next;
    pivot <= pivot_next;
    vi    <= vi_next;
    vj    <= vj_next;
  end

  `QSE_ASSERT(a_sp_bound, clk, rst, sp <= CNT_W'(MAX_ITEMS), "range stack overran")
  `QSE_ASSERT(a_scan_i_bound, clk, rst, (state == ST_SI_RD) |-> (i <= hi + CNT_W'(1)), "i scan")
  `QSE_ASSERT(a_scan_j_bound, clk, rst, (state == ST_SJ_RD) |-> (j >= lo), "j scan below range")
  `QSE_ASSERT(a_emit_free, clk, rst, emit.valid |-> out_free && (state == ST_EM_WAIT), "emit")
  `QSE_ASSERT(a_ovf_set, clk, rst, (item_valid && item_ready && (count == CNT_W'(MAX_ITEMS))) |=> ovf, "ovf")
  `QSE_ASSERT_NR(a_reset_state, clk, rst |=> (state == ST_LOAD) && (count == '0) && !ovf, "reset")

endmodule

`default_nettype wire

@@ sv/quicksort_engine_top.sv @@
// ----------------------------------------------------------------------------
// Quicksort engine
// Collects a set of signed 32-bit elements, sorts it ascending by quicksort
// and streams the sorted elements out with the final one marked.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                               Carries
//   -------   ---------------------------------   ---------------------------
//   input     item_valid, item_ready, item        value, last_item
//   output    result_valid, result_ready, result  sorted_value, last_out,
//                                                  overflow
//
// Loading accepts one input transaction per cycle. After the transaction
// that carries last_item, sorting runs on one comparator over the element
// store, whose single read port serves one read at a time: each compare
// first reads its element, and each swap writes its two elements in turn.
// Emitting each result takes a store read followed by the hand-off into
// the output register. Reset is synchronous and returns
// the block to loading with an empty set and a clear overflow flag. A stall
// on the output holds the sequencer, while a waiting result does not keep
// the next set from loading.
// ----------------------------------------------------------------------------
`default_nettype none

module quicksort_engine_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire qse_pkg::in_item_t  item,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output qse_pkg::out_item_t      result
);

  import qse_pkg::*;

  store_req_t store_req;
  stack_req_t stack_req;
  emit_t      emit;

  logic [VALUE_W-1:0] store_rdata;
  logic [STK_W-1:0]   stack_rdata;
  logic               out_free;

  // Element store: the set being sorted, sorted in place.
  qse_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk   (clk),
    .we    (store_req.we),
    .waddr (store_req.waddr),
    .wdata (store_req.wdata),
    .raddr (store_req.raddr),
    .rdata (store_rdata)
  );

  // Range stack: pending {lo, hi} index pairs still to be partitioned.
  qse_ram #(
    .WIDTH (STK_W),
    .DEPTH (MAX_ITEMS)
  ) u_stack (
    .clk   (clk),
    .we    (stack_req.we),
    .waddr (stack_req.waddr),
    .wdata (stack_req.wdata),
    .raddr (stack_req.raddr),
    .rdata (stack_rdata)
  );

  qse_sequencer u_seq (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item        (item),
    .item_ready  (item_ready),
    .store_rdata (store_rdata),
    .stack_rdata (stack_rdata),
    .out_free    (out_free),
    .store_req   (store_req),
    .stack_req   (stack_req),
    .emit        (emit)
  );

  // Output register: it takes a new result whenever it is empty or its
  // current transaction completes in this cycle.
  assign out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emit.valid) begin
      result <= emit.data;
    end
  end

endmodule

`default_nettype wire

@@ bench/tb_quicksort_engine_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quicksort engine testbench
// Streams sets of signed elements into the engine, keeps a sorted copy of
// each set as it loads, and checks every emitted element, its end marker and
// its overflow flag against that copy, with random idling on both channels.
// ----------------------------------------------------------------------------

// Tracks the set being loaded and the sorted results that are still due.
class sorted_set_tracker;
  logic signed [qse_pkg::VALUE_W-1:0] held_elems[$];
  qse_pkg::out_item_t                 due_sorted[$];
  bit                                 dropped_any;
  int                                 fail_count;

  // Called for every accepted input transaction.
  function void note_element(qse_pkg::in_item_t it);
    int                                 pos;
    logic signed [qse_pkg::VALUE_W-1:0] v;
    qse_pkg::out_item_t                 r;
    v = $signed(it.value);
    if (held_elems.size() < qse_pkg::MAX_ITEMS) begin
      // Insertion keeps the held set in ascending order at all times.
      pos = held_elems.size();
      while (pos > 0 && held_elems[pos-1] > v) pos--;
      held_elems.insert(pos, v);
    end else begin
      dropped_any = 1'b1;
    end
    if (it.last_item) begin
      foreach (held_elems[k]) begin
        r.sorted_value = held_elems[k];
        r.last_out     = (k == held_elems.size() - 1);
        r.overflow     = dropped_any;
        due_sorted.push_back(r);
      end
      held_elems.delete();
      dropped_any = 1'b0;
    end
  endfunction

  // Called for every accepted output transaction.
  function void check_sorted(qse_pkg::out_item_t got);
    qse_pkg::out_item_t want;
    if (due_sorted.size() == 0) begin
      $error("unexpected result: sorted_value %0d last_out %0b overflow %0b",
             $signed(got.sorted_value), got.last_out, got.overflow);
      fail_count++;
      return;
    end
    want = due_sorted.pop_front();
    if (got.sorted_value !== want.sorted_value) begin
      $error("sorted_value: expected %0d, actual %0d",
             $signed(want.sorted_value), $signed(got.sorted_value));
      fail_count++;
    end
    if (got.last_out !== want.last_out) begin
      $error("last_out: expected %0b, actual %0b", want.last_out, got.last_out);
      fail_count++;
    end
    if (got.overflow !== want.overflow) begin
      $error("overflow: expected %0b, actual %0b", want.overflow, got.overflow);
      fail_count++;
    end
  endfunction
endclass

module tb_quicksort_engine_top;
  import qse_pkg::*;

  // Roughly how many random elements to load after the directed sets.
  localparam int RANDOM_ITEMS = 345;
  // Idling stops for both channels once this few random elements remain.
  localparam int CALM_TAIL    = 60;
  // Generous bound on the whole run, counted in clock cycles.
  localparam int CYCLE_LIMIT  = 400000;
  // Cycles allowed for a stray result to show up after the last one due.
  localparam int DRAIN_CYCLES = 200;

  logic      clk;
  logic      rst;
  logic      item_valid;
  logic      item_ready;
  in_item_t  item;
  logic      result_valid;
  logic      result_ready;
  out_item_t result;

  sorted_set_tracker tracker;

  // Elements of the next set to send; the final one carries last_item.
  logic signed [VALUE_W-1:0] set_buf[$];
  // When set, neither channel idles any more.
  bit calm;
  int random_sent;

  quicksort_engine_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Every result transaction is checked at the rising edge that accepts it.
  // Both valid and ready are stable there, since the testbench only changes
  // its side at the falling edge.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) tracker.check_sorted(result);
  end

  // Output side. The receiver stalls in random bursts with ready high between
  // bursts, and stops stalling for good once the tail of the run starts.
  initial begin : result_sink
    int stall_left;
    stall_left   = 0;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        result_ready <= 1'b0;
        stall_left--;
      end else begin
        result_ready <= 1'b1;
        if (!calm && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 6);
      end
    end
  end

  // Run limit. A hang anywhere, a lost result or a stuck ready, ends here.
  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Holds the input channel idle for a random burst now and then. The
  // payload wanders while valid is low, which the engine must ignore.
  task automatic maybe_idle_input();
    int n;
    if (calm || $urandom_range(0, 3) != 0) return;
    n = $urandom_range(1, 6);
    repeat (n) begin
      @(negedge clk);
      item_valid <= 1'b0;
      item       <= {$urandom, 1'($urandom)};
    end
  endtask

  // Presents one element and waits for the engine to take it. Valid stays
  // high with the same payload until the accepting edge, where the
  // transaction is handed to the tracker.
  task automatic send_element(input logic signed [VALUE_W-1:0] v, input logic is_last);
    in_item_t it;
    it.value     = v;
    it.last_item = is_last;
    @(negedge clk);
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (!item_ready);
    tracker.note_element(it);
  endtask

  // Sends the buffered set, marking its final element, and empties it.
  task automatic send_set();
    foreach (set_buf[k]) begin
      maybe_idle_input();
      send_element(set_buf[k], k == set_buf.size() - 1);
    end
    set_buf.delete();
  endtask

  // Draws one element. Each set picks a style, so some sets are full of
  // duplicates or extremes and others spread over the whole 32-bit range.
  function automatic logic signed [VALUE_W-1:0] pick_value(int style);
    logic signed [VALUE_W-1:0] v;
    case (style)
      0: v = $urandom;
      1: v = $signed($urandom_range(0, 15)) - 8;
      2: begin
        case ($urandom_range(0, 4))
          0: v = 32'sh7FFF_FFFF;
          1: v = 32'sh8000_0000;
          2: v = 32'sh0000_0000;
          3: v = -32'sd1;
          default: v = 32'sd1;
        endcase
      end
      default: v = $urandom_range(0, 1) ? 32'sh7FFF_FFF0 + $urandom_range(0, 15)
                                        : 32'sh8000_0000 + $urandom_range(0, 15);
    endcase
    return v;
  endfunction

  initial begin : stimulus
    int r;
    int set_len;
    int style;

    tracker = new;
    calm        = 1'b0;
    random_sent = 0;

    // All inputs known from time zero; reset held high at the start.
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed sets. A set of one at each extreme of the value range.
    set_buf = '{32'sh7FFF_FFFF};
    send_set();
    set_buf = '{32'sh8000_0000};
    send_set();
    // Extremes, sign boundary, alternating bit patterns and duplicates.
    set_buf = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, -32'sd1, 32'sd1,
                32'sh5555_5555, 32'shAAAA_AAAA, 32'sh8000_0000, 32'sh7FFF_FFFF};
    send_set();
    // Descending order, which puts every pivot at an end of its range.
    set_buf = '{32'sd100, 32'sd50, 32'sd0, -32'sd50, -32'sd100};
    send_set();
    // All elements equal, so neither scan stops on an element equal to the pivot.
    set_buf = '{32'sd7, 32'sd7, 32'sd7, 32'sd7};
    send_set();
    // Already ascending.
    set_buf = '{-32'sd3, 32'sd2, 32'sd9, 32'sd1000};
    send_set();

    // Random sets. Most are short so that the sort stays quick; a few fill
    // the store exactly and a few run past it, which drops the excess,
    // including a final element that arrives with the store already full.
    while (random_sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 60)      set_len = $urandom_range(1, 8);
      else if (r < 85) set_len = $urandom_range(9, 20);
      else if (r < 95) set_len = $urandom_range(21, MAX_ITEMS);
      else             set_len = $urandom_range(MAX_ITEMS, MAX_ITEMS + 6);
      style = $urandom_range(0, 3);
      repeat (set_len) set_buf.push_back(pick_value(style));
      calm = (random_sent + set_len >= RANDOM_ITEMS - CALM_TAIL);
      send_set();
      random_sent += set_len;
    end

    @(negedge clk);
    item_valid <= 1'b0;

    // Wait for every due result, then give the engine time to show any
    // result it should not produce.
    while (tracker.due_sorted.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/qse_pkg.sv
sv/qse_ram.sv
sv/qse_sequencer.sv
sv/quicksort_engine_top.sv
bench/tb_quicksort_engine_top.sv
